// ----- sv/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Coefficient register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_reg_idx;

    // Reference temperature (20.00 degC) and very-low threshold offset.
    localparam logic signed [18:0] TEMP_REF   = 19'sd2000;
    localparam logic signed [18:0] VLOW_OFS   = 19'sd3500;
    localparam logic signed [17:0] VLOW_LIMIT = -18'sd3500;

    // Saturation bounds of the pressure result.
    localparam logic [31:0] PRESS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PRESS_MIN = 32'h8000_0000;

    // Factory coefficients C1..C6.
    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } t_coeffs;

    // First-order results handed to the second-order section.
    typedef struct packed {
        logic        [23:0] d1;
        logic signed [18:0] temp;
        logic signed [17:0] dtemp;
        logic signed [36:0] off;
        logic signed [35:0] sens;
        logic        [16:0] t2;
    } t_first;

    // Corrected values handed to the pressure section.
    typedef struct packed {
        logic        [23:0] d1;
        logic signed [18:0] temp;
        logic signed [42:0] off;
        logic signed [41:0] sens;
    } t_second;

endpackage

// ----- sv/bsc_in_if.sv -----
// ----------------------------------------------------------------------------
// bsc_in_if
// Input channel: one raw pressure and temperature conversion pair per item.
// ----------------------------------------------------------------------------
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature,
                    input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature,
                  output ready);
endinterface

// ----- sv/bsc_out_if.sv -----
// ----------------------------------------------------------------------------
// bsc_out_if
// Output channel: one compensated temperature and pressure per item.
// ----------------------------------------------------------------------------
interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] temperature;
    logic signed [31:0] pressure;

    modport source (output valid, output temperature, output pressure,
                    input ready);
    modport sink (input valid, input temperature, input pressure,
                  output ready);
endinterface

// ----- sv/baro_sensor_second_order_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_sensor_second_order_compensation
// Factory-coefficient compensation of a barometric sensor with second-order
// temperature correction.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six factory coefficients C1..C6 through the write port
//   (i_cfg_we, i_cfg_idx, i_cfg_data) while no item is in flight. Each
//   input item on i_in carries one raw pressure D1 and raw temperature D2.
//   Each output item on o_out carries temperature in 0.01 degC and pressure
//   in 0.01 mbar, saturated to the signed 32-bit range.
//   The datapath is a nine-stage pipeline in three sections (first order,
//   second order, pressure). Each result is presented on o_out from the
//   registers of the last stage. One item per cycle is taken while the
//   output is consumed.
//   The widest product, D1*SENS, is split into two partial products over
//   one stage and summed in the next, which sets the stage depth.
//   Each stage advances on its own when empty, so while the receiver stalls
//   the pipeline keeps filling until all nine stages hold an item; then
//   i_in.ready drops and nothing is lost or repeated.
//   Reset clears all valid bits and sets every coefficient to zero.
// ----------------------------------------------------------------------------
module baro_sensor_second_order_compensation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bsc_in_if.sink                           i_in,
    bsc_out_if.source                        o_out
);
    import bsc_pkg::*;

    t_coeffs r_coeffs;

    logic    s_first_valid;
    logic    s_first_ready;
    t_first  s_first;
    logic    s_second_valid;
    logic    s_second_ready;
    t_second s_second;

    // Coefficient registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_C1:  r_coeffs.c1 <= i_cfg_data;
                REG_C2:  r_coeffs.c2 <= i_cfg_data;
                REG_C3:  r_coeffs.c3 <= i_cfg_data;
                REG_C4:  r_coeffs.c4 <= i_cfg_data;
                REG_C5:  r_coeffs.c5 <= i_cfg_data;
                REG_C6:  r_coeffs.c6 <= i_cfg_data;
                default: r_coeffs <= r_coeffs;
            endcase
        end
    end

    // First-order section.
    bsc_first u_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coeffs (r_coeffs),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_d1     (i_in.raw_pressure),
        .i_d2     (i_in.raw_temperature),
        .o_valid  (s_first_valid),
        .i_ready  (s_first_ready),
        .o_data   (s_first)
    );

    // Second-order correction.
    bsc_second u_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_first_valid),
        .o_ready  (s_first_ready),
        .i_data   (s_first),
        .o_valid  (s_second_valid),
        .i_ready  (s_second_ready),
        .o_data   (s_second)
    );

    // Pressure and output register.
    bsc_press u_press (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_second_valid),
        .o_ready  (s_second_ready),
        .i_data   (s_second),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_temp   (o_out.temperature),
        .o_press  (o_out.pressure)
    );

endmodule

// ----- sv/bsc_first.sv -----
// ----------------------------------------------------------------------------
// bsc_first
// First-order compensation: dT, TEMP, OFF, SENS and the T2 term, three stages.
// ----------------------------------------------------------------------------
module bsc_first (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsc_pkg::t_coeffs i_coeffs,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [23:0]      i_d1,
    input  logic [23:0]      i_d2,
    output logic             o_valid,
    input  logic             i_ready,
    output bsc_pkg::t_first  o_data
);
    import bsc_pkg::*;

    logic [2:0] r_v;
    logic [2:0] s_adv;

    // Stage registers.
    logic        [23:0] r_d1_0;
    logic signed [24:0] r_dt;
    logic        [23:0] r_d1_1;
    logic signed [41:0] r_pt;
    logic signed [41:0] r_po;
    logic signed [41:0] r_ps;
    logic signed [49:0] r_sq;
    t_first             r_out;

    logic signed [24:0] n_dt;
    logic signed [17:0] n_dtemp;
    logic        [48:0] n_sq;
    logic        [50:0] n_t5;
    logic        [49:0] n_t3;
    t_first             n_out;

    // A stage moves when it is empty or the next one moves.
    assign s_adv[2] = !r_v[2] || i_ready;
    assign s_adv[1] = !r_v[1] || s_adv[2];
    assign s_adv[0] = !r_v[0] || s_adv[1];
    assign o_ready  = s_adv[0];
    assign o_valid  = r_v[2];
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_adv[0]) r_v[0] <= i_valid;
            if (s_adv[1]) r_v[1] <= r_v[0];
            if (s_adv[2]) r_v[2] <= r_v[1];
        end
    end

    // Temperature difference from the reference.
    assign n_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_coeffs.c5, 8'b0});

    always_ff @(posedge i_clk) begin
        if (s_adv[0]) begin
            r_d1_0 <= i_d1;
            r_dt   <= n_dt;
        end
    end

    // The four products of dT.
    always_ff @(posedge i_clk) begin
        if (s_adv[1]) begin
            r_d1_1 <= r_d1_0;
            r_pt   <= r_dt * $signed({1'b0, i_coeffs.c6});
            r_po   <= r_dt * $signed({1'b0, i_coeffs.c4});
            r_ps   <= r_dt * $signed({1'b0, i_coeffs.c3});
            r_sq   <= r_dt * r_dt;
        end
    end

    // Scale the products; the shifts are floor divisions.
    always_comb begin
        n_dtemp    = r_pt[40:23];
        n_sq       = r_sq[48:0];
        n_t5       = {n_sq, 2'b00} + {2'b00, n_sq};
        n_t3       = {n_sq, 1'b0} + {1'b0, n_sq};
        n_out.d1   = r_d1_1;
        n_out.dtemp = n_dtemp;
        n_out.temp = TEMP_REF + {n_dtemp[17], n_dtemp};
        n_out.off  = $signed({4'b0, i_coeffs.c2, 17'b0})
                   + {r_po[41], r_po[41:6]};
        n_out.sens = $signed({4'b0, i_coeffs.c1, 16'b0})
                   + {r_ps[41], r_ps[41:7]};
        if (n_dtemp[17]) begin
            n_out.t2 = n_t3[49:33];
        end else begin
            n_out.t2 = {4'b0, n_t5[50:38]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[2]) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- sv/bsc_second.sv -----
// ----------------------------------------------------------------------------
// bsc_second
// Second-order correction: low and very-low temperature terms, three stages.
// ----------------------------------------------------------------------------
module bsc_second (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bsc_pkg::t_first  i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output bsc_pkg::t_second o_data
);
    import bsc_pkg::*;

    logic [2:0] r_v;
    logic [2:0] s_adv;

    logic        [23:0] r_d1_0;
    logic signed [18:0] r_temp_0;
    logic signed [36:0] r_off_0;
    logic signed [35:0] r_sens_0;
    logic        [34:0] r_dev1;
    logic        [34:0] r_dev2;
    logic               r_low;
    logic               r_vlow;

    logic        [23:0] r_d1_1;
    logic signed [18:0] r_temp_1;
    logic signed [36:0] r_off_1;
    logic signed [35:0] r_sens_1;
    logic        [40:0] r_off2;
    logic        [39:0] r_sens2;

    t_second            r_out;

    logic signed [18:0] n_vl;
    logic signed [35:0] n_sq1;
    logic signed [37:0] n_sq2;
    logic        [40:0] n_o61;
    logic        [38:0] n_o17;
    logic        [39:0] n_s29;
    logic        [37:0] n_s9;
    logic        [40:0] n_off2;
    logic        [39:0] n_sens2;

    assign s_adv[2] = !r_v[2] || i_ready;
    assign s_adv[1] = !r_v[1] || s_adv[2];
    assign s_adv[0] = !r_v[0] || s_adv[1];
    assign o_ready  = s_adv[0];
    assign o_valid  = r_v[2];
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_adv[0]) r_v[0] <= i_valid;
            if (s_adv[1]) r_v[1] <= r_v[0];
            if (s_adv[2]) r_v[2] <= r_v[1];
        end
    end

    // Squared deviations from 20 degC and from -15 degC; final temperature.
    assign n_vl  = {i_data.dtemp[17], i_data.dtemp} + VLOW_OFS;
    assign n_sq1 = i_data.dtemp * i_data.dtemp;
    assign n_sq2 = n_vl * n_vl;

    always_ff @(posedge i_clk) begin
        if (s_adv[0]) begin
            r_d1_0   <= i_data.d1;
            r_temp_0 <= i_data.temp - $signed({2'b0, i_data.t2});
            r_off_0  <= i_data.off;
            r_sens_0 <= i_data.sens;
            r_dev1   <= n_sq1[34:0];
            r_dev2   <= n_sq2[34:0];
            r_low    <= i_data.dtemp[17];
            r_vlow   <= i_data.dtemp < VLOW_LIMIT;
        end
    end

    // OFF2 and SENS2 from shift-and-add constant multiples.
    always_comb begin
        n_o61 = {r_dev1, 6'b0} - {5'b0, r_dev1, 1'b0} - {6'b0, r_dev1};
        n_o17 = {r_dev2, 4'b0} + {4'b0, r_dev2};
        n_s29 = {r_dev1, 5'b0} - {4'b0, r_dev1, 1'b0} - {5'b0, r_dev1};
        n_s9  = {r_dev2, 3'b0} + {3'b0, r_dev2};
        n_off2  = '0;
        n_sens2 = '0;
        if (r_low) begin
            n_off2  = {4'b0, n_o61[40:4]};
            n_sens2 = {4'b0, n_s29[39:4]};
            if (r_vlow) begin
                n_off2  = n_off2 + {2'b0, n_o17};
                n_sens2 = n_sens2 + {2'b0, n_s9};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[1]) begin
            r_d1_1   <= r_d1_0;
            r_temp_1 <= r_temp_0;
            r_off_1  <= r_off_0;
            r_sens_1 <= r_sens_0;
            r_off2   <= n_off2;
            r_sens2  <= n_sens2;
        end
    end

    // Apply the corrections.
    always_ff @(posedge i_clk) begin
        if (s_adv[2]) begin
            r_out.d1   <= r_d1_1;
            r_out.temp <= r_temp_1;
            r_out.off  <= {{6{r_off_1[36]}}, r_off_1} - $signed({2'b0, r_off2});
            r_out.sens <= {{6{r_sens_1[35]}}, r_sens_1} - $signed({2'b0, r_sens2});
        end
    end

endmodule

// ----- sv/bsc_press.sv -----
// ----------------------------------------------------------------------------
// bsc_press
// Pressure: D1*SENS as two partial products, offset removal, saturation.
// ----------------------------------------------------------------------------
module bsc_press (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bsc_pkg::t_second   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [18:0] o_temp,
    output logic signed [31:0] o_press
);
    import bsc_pkg::*;

    logic [2:0] r_v;
    logic [2:0] s_adv;

    logic signed [18:0] r_temp_0;
    logic signed [42:0] r_off_0;
    logic        [44:0] r_lo;
    logic signed [45:0] r_hi;
    logic signed [18:0] r_temp_1;
    logic signed [42:0] r_off_1;
    logic signed [66:0] r_prod;
    logic signed [18:0] r_temp;
    logic signed [31:0] r_press;

    logic signed [47:0] n_x;
    logic signed [32:0] n_pw;
    logic signed [31:0] n_press;

    assign s_adv[2] = !r_v[2] || i_ready;
    assign s_adv[1] = !r_v[1] || s_adv[2];
    assign s_adv[0] = !r_v[0] || s_adv[1];
    assign o_ready  = s_adv[0];
    assign o_valid  = r_v[2];
    assign o_temp   = r_temp;
    assign o_press  = r_press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_adv[0]) r_v[0] <= i_valid;
            if (s_adv[1]) r_v[1] <= r_v[0];
            if (s_adv[2]) r_v[2] <= r_v[1];
        end
    end

    // Partial products on the low and high halves of SENS.
    always_ff @(posedge i_clk) begin
        if (s_adv[0]) begin
            r_temp_0 <= i_data.temp;
            r_off_0  <= i_data.off;
            r_lo     <= i_data.d1 * i_data.sens[20:0];
            r_hi     <= $signed({1'b0, i_data.d1}) * $signed(i_data.sens[41:21]);
        end
    end

    // Recombine into the full product.
    always_ff @(posedge i_clk) begin
        if (s_adv[1]) begin
            r_temp_1 <= r_temp_0;
            r_off_1  <= r_off_0;
            r_prod   <= $signed({r_hi, 21'b0}) + $signed({22'b0, r_lo});
        end
    end

    // Remove the offset, scale, and clip to the 32-bit range.
    always_comb begin
        n_x  = {{2{r_prod[66]}}, r_prod[66:21]} - {{5{r_off_1[42]}}, r_off_1};
        n_pw = n_x[47:15];
        if (n_pw[32] != n_pw[31]) begin
            n_press = n_pw[32] ? PRESS_MIN : PRESS_MAX;
        end else begin
            n_press = n_pw[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[2]) begin
            r_temp  <= r_temp_1;
            r_press <= n_press;
        end
    end

endmodule

// ----- tb/bsc_checker.sv -----
// ----------------------------------------------------------------------------
// bsc_checker
// Watches the configuration port and both channels of the barometric sensor
// compensation block. It predicts the compensated reading of every accepted
// item and compares it, field by field, with the results in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_checker
    import bsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bsc_in_if                     i_in_ch,
    bsc_out_if                    i_out_ch,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int REPORT_LIMIT = 10;

    // Saturation bounds of the pressure field, held at 64 bits.
    localparam longint PRESS_HI = 64'sd2147483647;
    localparam longint PRESS_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [18:0] temperature;
        logic signed [31:0] pressure;
    } reading_t;

    t_coeffs  coeffs = '0;
    reading_t pending_readings[$];
    reading_t want;
    reading_t got;
    int       fails = 0;
    int       checked = 0;
    int       reports = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // First-order compensation followed by the second-order correction.
    // All arithmetic is signed 64-bit; an arithmetic right shift of a signed
    // value is a division that rounds toward minus infinity.
    function automatic reading_t compensate(logic [23:0] d1_raw, logic [23:0] d2_raw,
                                            t_coeffs k);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, t2, off2, sens2, dev, p;
        reading_t r;
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = k.c1;
        c2 = k.c2;
        c3 = k.c3;
        c4 = k.c4;
        c5 = k.c5;
        c6 = k.c6;

        dt   = d2 - c5 * 256;
        temp = 2000 + ((dt * c6) >>> 23);
        off  = c2 * 131072 + ((c4 * dt) >>> 6);
        sens = c1 * 65536 + ((c3 * dt) >>> 7);

        // High temperature needs only a small temperature term.
        if (temp >= 2000) begin
            t2    = (5 * dt * dt) >>> 38;
            off2  = 0;
            sens2 = 0;
        end else begin
            dev   = (temp - 2000) * (temp - 2000);
            t2    = (3 * dt * dt) >>> 33;
            off2  = (61 * dev) >>> 4;
            sens2 = (29 * dev) >>> 4;
            // Very low temperature adds a further quadratic term.
            if (temp < -1500) begin
                dev   = (temp + 1500) * (temp + 1500);
                off2  = off2 + 17 * dev;
                sens2 = sens2 + 9 * dev;
            end
        end

        off  = off - off2;
        sens = sens - sens2;
        temp = temp - t2;
        p    = (((d1 * sens) >>> 21) - off) >>> 15;

        if (p > PRESS_HI) begin
            p = PRESS_HI;
        end
        if (p < PRESS_LO) begin
            p = PRESS_LO;
        end

        r.temperature = temp[18:0];
        r.pressure    = p[31:0];
        return r;
    endfunction

    // Track the coefficients, queue a prediction per accepted item and check
    // every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coeffs <= '0;
            pending_readings.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                pending_readings.push_back(compensate(i_in_ch.raw_pressure,
                                                      i_in_ch.raw_temperature, coeffs));
            end

            if (i_out_ch.valid && i_out_ch.ready) begin
                got.temperature = i_out_ch.temperature;
                got.pressure    = i_out_ch.pressure;
                checked++;
                if (pending_readings.size() == 0) begin
                    fails++;
                    if (reports < REPORT_LIMIT) begin
                        reports++;
                        $display("%0t: unexpected result temperature %0d pressure %0d",
                                 $time, got.temperature, got.pressure);
                    end
                end else begin
                    want = pending_readings.pop_front();
                    if (want.temperature !== got.temperature ||
                        want.pressure !== got.pressure) begin
                        fails++;
                        if (reports < REPORT_LIMIT) begin
                            reports++;
                            $display("%0t: result %0d temperature exp %0d got %0d, %s",
                                     $time, checked, want.temperature, got.temperature,
                                     $sformatf("pressure exp %0d got %0d",
                                               want.pressure, got.pressure));
                        end
                    end
                end
            end

            // Writes to indexes outside the coefficient set are dropped.
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_C1: coeffs.c1 <= i_cfg_data;
                    REG_C2: coeffs.c2 <= i_cfg_data;
                    REG_C3: coeffs.c3 <= i_cfg_data;
                    REG_C4: coeffs.c4 <= i_cfg_data;
                    REG_C5: coeffs.c5 <= i_cfg_data;
                    REG_C6: coeffs.c6 <= i_cfg_data;
                    default: ;
                endcase
            end
        end

        o_pending    <= pending_readings.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the barometric sensor compensation block. A directed set of
// raw pairs covers the field extremes and each temperature branch, then
// random pairs run under several coefficient sets and flow-control mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import bsc_pkg::*;

    localparam int  CLK_PERIOD      = 20;
    localparam int  PIPE_LATENCY    = 9;
    localparam int  RANDOM_PHASES   = 8;
    localparam int  PAIRS_PER_PHASE = 60;
    localparam int  TIMEOUT_CYCLES  = 100_000;
    localparam logic [23:0] RAW_MAX   = 24'hFF_FFFF;
    localparam logic [15:0] COEFF_MAX = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNMAPPED = 3'd6;

    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_IDLE,
        FLOW_RECV_STALL,
        FLOW_BOTH
    } flow_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic tx_valid = 1'b0;
    logic [23:0] tx_pressure = '0;
    logic [23:0] tx_temperature = '0;
    logic rx_ready = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int pairs_sent = 0;
    int coeff_sets = 0;
    int fail_count;
    int pending;
    int checked;

    bsc_in_if  in_ch();
    bsc_out_if out_ch();

    assign in_ch.valid           = tx_valid;
    assign in_ch.raw_pressure    = tx_pressure;
    assign in_ch.raw_temperature = tx_temperature;
    assign out_ch.ready          = rx_ready;

    baro_sensor_second_order_compensation dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    bsc_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge clk) begin
        rx_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("[baro_sensor_second_order_compensation] ERROR");
        $finish;
    end

    task automatic set_flow(flow_e f);
        send_idle_pct  = (f == FLOW_SEND_IDLE) ? 80 : (f == FLOW_BOTH) ? 23 : 0;
        recv_stall_pct = (f == FLOW_RECV_STALL) ? 80 : (f == FLOW_BOTH) ? 23 : 0;
    endtask

    // Drop valid and hold off until every predicted reading has arrived.
    task automatic wait_drained();
        tx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Reload all six coefficients once the pipeline is empty. A write to an
    // unmapped index follows; it must leave the coefficients alone.
    task automatic reload_coeffs(t_coeffs k);
        wait_drained();
        repeat (PIPE_LATENCY) @(posedge clk);
        write_reg(REG_C1, k.c1);
        write_reg(REG_C2, k.c2);
        write_reg(REG_C3, k.c3);
        write_reg(REG_C4, k.c4);
        write_reg(REG_C5, k.c5);
        write_reg(REG_C6, k.c6);
        write_reg(FIRST_UNMAPPED + CFG_IDX_W'($urandom_range(1)), CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        coeff_sets++;
    endtask

    // Offer one raw pair, after a random run of idle cycles, and wait until
    // it is accepted. Valid stays high so the next item can follow at once.
    task automatic send_pair(logic [23:0] d1, logic [23:0] d2);
        while ($urandom_range(99) < send_idle_pct) begin
            tx_valid <= 1'b0;
            @(posedge clk);
        end
        tx_valid       <= 1'b1;
        tx_pressure    <= d1;
        tx_temperature <= d2;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        pairs_sent++;
    endtask

    initial begin
        t_coeffs     k;
        logic [23:0] base;
        logic [23:0] d1;
        int          d2;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_flow(FLOW_FREE);

        // Reset coefficients are all zero.
        send_pair(RAW_MAX, 24'h12_3456);

        // Typical factory coefficients: every temperature branch and both
        // sides of the 20 degC and -15 degC boundaries.
        k    = {16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
        base = {k.c5, 8'h00};
        reload_coeffs(k);
        send_pair(24'h00_0000, 24'h00_0000);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, 24'h00_0000);
        send_pair(24'h00_0000, RAW_MAX);
        send_pair(24'd6465444, base);
        send_pair(24'd6465444, base - 24'd1);
        send_pair(24'd6465444, base + 24'd1);
        send_pair(24'd6465444, base - 24'd500000);
        send_pair(24'hAA_AAAA, base - 24'd1042000);
        send_pair(24'h55_5555, base - 24'd1043000);

        // All coefficients at their maximum.
        k    = {6{COEFF_MAX}};
        base = {k.c5, 8'h00};
        reload_coeffs(k);
        send_pair(RAW_MAX, 24'h00_0000);
        send_pair(24'h00_0000, 24'h00_0000);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, base);

        // All coefficients written to zero.
        reload_coeffs('0);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, 24'h00_0000);

        // Zero reference and full sensitivity: the hottest reading there is.
        k = {COEFF_MAX, 16'h0000, COEFF_MAX, 16'h0000, 16'h0000, COEFF_MAX};
        reload_coeffs(k);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, 24'h00_0000);

        // Random phases, each with its own coefficients and flow mix. Raw
        // temperatures are drawn over the whole range, near the reference or
        // below it, so that every branch of the second-order correction is hit often.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            k = {$urandom, $urandom, $urandom};
            if (p == 0) begin
                k.c5 = COEFF_MAX;
            end else if (p == 4) begin
                k.c6 = COEFF_MAX;
                k.c1 = 16'h0000;
            end
            base = {k.c5, 8'h00};
            reload_coeffs(k);
            set_flow(flow_e'(p % 4));

            for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
                if (n == PAIRS_PER_PHASE / 2) begin
                    wait_drained();
                end
                case ($urandom_range(15))
                    0: d1 = 24'h00_0000;
                    1: d1 = RAW_MAX;
                    default: d1 = 24'($urandom);
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3: d2 = int'($urandom_range(RAW_MAX));
                    4, 5, 6: d2 = int'(base) + int'($urandom_range(8192)) - 4096;
                    default: d2 = int'(base) - int'($urandom_range(1 << 22));
                endcase
                if (d2 < 0) begin
                    d2 = 0;
                end else if (d2 > int'(RAW_MAX)) begin
                    d2 = int'(RAW_MAX);
                end
                send_pair(d1, 24'(d2));
            end
        end

        // Let the pipeline empty, then allow time for any stray result.
        wait_drained();
        repeat (PIPE_LATENCY * 4) @(posedge clk);

        $display("Sent %0d raw pairs under %0d coefficient sets and four flow mixes.",
                 pairs_sent, coeff_sets);
        $display("Compared %0d readings, %0d failures.", checked, fail_count);
        if (fail_count == 0) begin
            $display("[baro_sensor_second_order_compensation] OK");
        end else begin
            $display("[baro_sensor_second_order_compensation] ERROR");
        end
        $finish;
    end

endmodule
